/* hdl/lru_page_replacement_macros.svh */
// Assertion macros shared by the page replacement RTL.
// The macros expect a clock named clk and an active-low reset named arst_n in scope.
`ifndef LRU_PAGE_REPLACEMENT_MACROS_SVH
`define LRU_PAGE_REPLACEMENT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define LRUPR_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define LRUPR_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hdl/lrupr_pkg.sv */
// Shared types, sizes and helpers for the LRU page replacement block.
// No dependencies; every other RTL module imports this package.
`default_nettype none

package lrupr_pkg;

	localparam int FRAMES    = 16;
	localparam int PAGE_BITS = 16;

	localparam int PAGE_FIELD_W = 16;
	localparam int SLOT_FIELD_W = 4;
	localparam int CFG_W        = 5;
	localparam int CNT_W        = 16;

	// Stored page width: compare only the low PAGE_BITS of the field.
	localparam int PAGE_W = (PAGE_BITS < PAGE_FIELD_W) ? PAGE_BITS : PAGE_FIELD_W;
	localparam int SLOT_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;
	localparam int RANK_W = SLOT_W;
	localparam int TREE_N = 1 << SLOT_W;

	localparam logic [RANK_W-1:0] RANK_MAX = RANK_W'(FRAMES - 1);
	localparam logic [CNT_W-1:0]  CNT_MAX  = {CNT_W{1'b1}};
	localparam logic [CFG_W-1:0]  CFG_RESET = CFG_W'(16);

	typedef struct packed {
		logic [PAGE_FIELD_W-1:0] page_number;
		logic                    final_reference;
	} in_item_t;

	typedef struct packed {
		logic                    hit;
		logic [SLOT_FIELD_W-1:0] frame_slot;
		logic                    evicted_valid;
		logic [PAGE_FIELD_W-1:0] evicted_page;
		logic [CNT_W-1:0]        fault_total;
		logic [CNT_W-1:0]        hit_total;
	} out_item_t;

	// Reference as held in the queue between front and back.
	typedef struct packed {
		logic [PAGE_W-1:0] page;
		logic              last;
	} ref_t;

	function automatic logic [SLOT_FIELD_W-1:0] slot_field(input logic [SLOT_W-1:0] s);
		logic [SLOT_W+SLOT_FIELD_W-1:0] wide;
		wide = {{SLOT_FIELD_W{1'b0}}, s};
		return wide[SLOT_FIELD_W-1:0];
	endfunction

	function automatic logic [PAGE_FIELD_W-1:0] page_field(input logic [PAGE_W-1:0] p);
		logic [PAGE_W+PAGE_FIELD_W-1:0] wide;
		wide = {{PAGE_FIELD_W{1'b0}}, p};
		return wide[PAGE_FIELD_W-1:0];
	endfunction

endpackage

`default_nettype wire

/* hdl/lru_page_replacement.sv */
// LRU page replacement block.
//
// Input channel (in_valid / in_stall / in_data) carries one page reference per
// transfer: a page number and a flag that marks the last reference of a run.
// Output channel (out_valid / out_stall / out_data) carries one result per
// reference: hit or fault, the frame now holding the page, any evicted page,
// and the saturating fault and hit totals of the run so far.
// cfg_we / cfg_wdata write frames_in_use, the number of frames managed; write
// it only while no reference is in flight.
// A reference goes through a two-entry input queue, then through a lookup state
// for the parallel tag compare and oldest-frame search and an update state for
// the recency and frame update, which loads the result into the output register.
// The block takes the next reference from the queue only after that update,
// set by the compare-then-update loop on the frame table.
// When out_stall is high the finished result waits in the output register; the
// queue keeps taking references until both entries are full, then in_stall
// rises. Reset empties the queue, clears valid bits, ranks and totals, and sets
// frames_in_use to 16. After the final reference the run state clears again.
// Depends on lrupr_pkg, lrupr_front and lrupr_engine.
`default_nettype none

module lru_page_replacement
	import lrupr_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             cfg_we,
	input  wire logic [CFG_W-1:0] cfg_wdata,
	input  wire logic             in_valid,
	output logic                  in_stall,
	input  wire in_item_t         in_data,
	output logic                  out_valid,
	input  wire logic             out_stall,
	output out_item_t             out_data
);

	logic q_valid;
	ref_t q_data;
	logic q_pop;

	// Front end: takes each transfer and queues the trimmed reference.
	lrupr_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_data  (in_data),
		.q_valid  (q_valid),
		.q_data   (q_data),
		.q_pop    (q_pop)
	);

	// Back end: looks the reference up, updates recency and emits the result.
	lrupr_engine u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.q_valid   (q_valid),
		.q_data    (q_data),
		.q_pop     (q_pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

endmodule

`default_nettype wire

/* hdl/lrupr_front.sv */
// Front end: accepts page references and holds them in a two-entry queue.
// Depends on lrupr_pkg for the item and queue entry types.
`default_nettype none

module lrupr_front
	import lrupr_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     in_valid,
	output logic          in_stall,
	input  wire in_item_t in_data,
	output logic          q_valid,
	output ref_t          q_data,
	input  wire logic     q_pop
);

	ref_t       ent_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;
	logic       push;
	ref_t       decoded;

	assign in_stall = (cnt_q == 2'd2);
	assign push     = in_valid && !in_stall;
	assign q_valid  = (cnt_q != 2'd0);
	assign q_data   = ent_q[rd_ptr_q];

	// Trim the page to the compared width and pick out the end-of-run mark.
	assign decoded.page = in_data.page_number[PAGE_W-1:0];
	assign decoded.last = in_data.final_reference;

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q] <= decoded;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (q_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			unique case ({push, q_pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

`default_nettype wire

/* hdl/lrupr_engine.sv */
// Back end: frame table, recency ranks, run counters and the result register.
// Depends on lrupr_pkg and on the assertion macros header.
`default_nettype none
`include "lru_page_replacement_macros.svh"

module lrupr_engine
	import lrupr_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             cfg_we,
	input  wire logic [CFG_W-1:0] cfg_wdata,
	input  wire logic             q_valid,
	input  wire ref_t             q_data,
	output logic                  q_pop,
	output logic                  out_valid,
	input  wire logic             out_stall,
	output out_item_t             out_data
);

	typedef enum logic {
		S_LOOK,
		S_UPDATE
	} state_t;

	state_t             st_q;
	logic [CFG_W-1:0]   frames_in_use_q;
	logic [PAGE_W-1:0]  pages_q [FRAMES];
	logic [FRAMES-1:0]  valid_q;
	logic [RANK_W-1:0]  rank_q [FRAMES];
	logic [CNT_W-1:0]   fault_q;
	logic [CNT_W-1:0]   hit_q;
	logic               out_valid_q;
	out_item_t          out_q;

	// Lookup results carried into the update cycle.
	logic [PAGE_W-1:0]  page_s1;
	logic               last_s1;
	logic               hit_s1;
	logic               fill_s1;
	logic [SLOT_W-1:0]  slot_s1;
	logic [RANK_W-1:0]  rank_s1;
	logic [PAGE_W-1:0]  ev_page_s1;

	logic [TREE_N-1:0]  act;
	logic [TREE_N-1:0]  match;
	logic [TREE_N-1:0]  empty;
	logic               match_any;
	logic               empty_any;
	logic [SLOT_W-1:0]  match_idx;
	logic [SLOT_W-1:0]  empty_idx;
	logic [SLOT_W-1:0]  slot_sel;
	logic [RANK_W-1:0]  tr_rank [2*TREE_N];
	logic [SLOT_W-1:0]  tr_idx  [2*TREE_N];
	logic               tr_ok   [2*TREE_N];
	logic [SLOT_W-1:0]  lru_idx;

	logic               upd_fire;
	logic [RANK_W-1:0]  rank_n [FRAMES];
	logic [FRAMES-1:0]  valid_n;
	logic [CNT_W-1:0]   fault_n;
	logic [CNT_W-1:0]   hit_n;
	out_item_t          res;

	assign q_pop     = (st_q == S_LOOK) && q_valid;
	assign upd_fire  = (st_q == S_UPDATE) && (!out_valid_q || !out_stall);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// Parallel tag compare and empty-frame search over the active frames.
	// Frame zero is always active, so a count of zero behaves as one.
	always_comb begin
		act       = '0;
		match     = '0;
		empty     = '0;
		match_any = 1'b0;
		empty_any = 1'b0;
		match_idx = '0;
		empty_idx = '0;
		for (int i = 0; i < FRAMES; i++) begin
			act[i]   = (i == 0) || (32'(i) < 32'(frames_in_use_q));
			match[i] = act[i] && valid_q[i] && (pages_q[i] == q_data.page);
			empty[i] = act[i] && !valid_q[i];
		end
		for (int i = FRAMES - 1; i >= 0; i--) begin
			if (match[i]) begin
				match_any = 1'b1;
				match_idx = SLOT_W'(i);
			end
			if (empty[i]) begin
				empty_any = 1'b1;
				empty_idx = SLOT_W'(i);
			end
		end
	end

	// Oldest active frame by a balanced tree; equal ranks keep the lower slot.
	always_comb begin
		for (int i = 0; i < 2 * TREE_N; i++) begin
			tr_rank[i] = '0;
			tr_idx[i]  = '0;
			tr_ok[i]   = 1'b0;
		end
		for (int i = 0; i < FRAMES; i++) begin
			tr_rank[TREE_N + i] = rank_q[i];
			tr_idx[TREE_N + i]  = SLOT_W'(i);
			tr_ok[TREE_N + i]   = act[i];
		end
		for (int k = TREE_N - 1; k >= 1; k--) begin
			if (tr_ok[2*k+1] && (!tr_ok[2*k] || (tr_rank[2*k+1] > tr_rank[2*k]))) begin
				tr_rank[k] = tr_rank[2*k+1];
				tr_idx[k]  = tr_idx[2*k+1];
			end else begin
				tr_rank[k] = tr_rank[2*k];
				tr_idx[k]  = tr_idx[2*k];
			end
			tr_ok[k] = tr_ok[2*k] || tr_ok[2*k+1];
		end
		lru_idx = tr_idx[1];
	end

	always_comb begin
		priority if (match_any) begin
			slot_sel = match_idx;
		end else if (empty_any) begin
			slot_sel = empty_idx;
		end else begin
			slot_sel = lru_idx;
		end
	end

	// Recency update. A fill ages every valid frame below the ceiling; a hit or
	// a replacement ages only the frames younger than the touched one.
	always_comb begin
		valid_n = valid_q;
		for (int j = 0; j < FRAMES; j++) begin
			rank_n[j] = rank_q[j];
			if (fill_s1) begin
				if (valid_q[j] && (rank_q[j] < RANK_MAX)) begin
					rank_n[j] = rank_q[j] + RANK_W'(1);
				end
			end else if ((SLOT_W'(j) != slot_s1) && valid_q[j] && (rank_q[j] < rank_s1)) begin
				rank_n[j] = rank_q[j] + RANK_W'(1);
			end
		end
		rank_n[slot_s1]  = '0;
		valid_n[slot_s1] = 1'b1;

		fault_n = fault_q;
		hit_n   = hit_q;
		if (hit_s1) begin
			if (hit_q != CNT_MAX) begin
				hit_n = hit_q + CNT_W'(1);
			end
		end else if (fault_q != CNT_MAX) begin
			fault_n = fault_q + CNT_W'(1);
		end

		res.hit           = hit_s1;
		res.frame_slot    = slot_field(slot_s1);
		res.evicted_valid = !hit_s1 && !fill_s1;
		res.evicted_page  = (!hit_s1 && !fill_s1) ? page_field(ev_page_s1) : '0;
		res.fault_total   = fault_n;
		res.hit_total     = hit_n;
	end

	always_ff @(posedge clk) begin
		if (upd_fire && !hit_s1) begin
			pages_q[slot_s1] <= page_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q            <= S_LOOK;
			frames_in_use_q <= CFG_RESET;
			valid_q         <= '0;
			fault_q         <= '0;
			hit_q           <= '0;
			out_valid_q     <= 1'b0;
			out_q           <= '0;
			page_s1         <= '0;
			last_s1         <= 1'b0;
			hit_s1          <= 1'b0;
			fill_s1         <= 1'b0;
			slot_s1         <= '0;
			rank_s1         <= '0;
			ev_page_s1      <= '0;
			for (int j = 0; j < FRAMES; j++) begin
				rank_q[j] <= '0;
			end
		end else begin
			if (cfg_we) begin
				frames_in_use_q <= cfg_wdata;
			end
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (st_q)
				S_LOOK: begin
					if (q_valid) begin
						page_s1    <= q_data.page;
						last_s1    <= q_data.last;
						hit_s1     <= match_any;
						fill_s1    <= !match_any && empty_any;
						slot_s1    <= slot_sel;
						rank_s1    <= rank_q[slot_sel];
						ev_page_s1 <= pages_q[lru_idx];
						st_q       <= S_UPDATE;
					end
				end
				S_UPDATE: begin
					if (upd_fire) begin
						out_q       <= res;
						out_valid_q <= 1'b1;
						st_q        <= S_LOOK;
						if (last_s1) begin
							valid_q <= '0;
							fault_q <= '0;
							hit_q   <= '0;
							for (int j = 0; j < FRAMES; j++) begin
								rank_q[j] <= '0;
							end
						end else begin
							valid_q <= valid_n;
							fault_q <= fault_n;
							hit_q   <= hit_n;
							for (int j = 0; j < FRAMES; j++) begin
								rank_q[j] <= rank_n[j];
							end
						end
					end
				end
				default: st_q <= S_LOOK;
			endcase
		end
	end

	`LRUPR_ASSERT_NEXT(a_pop_then_update, q_pop, st_q == S_UPDATE, "lookup did not lead to update")
	`LRUPR_ASSERT_NEXT(a_update_loads_result, upd_fire, out_valid_q, "update lost its result")
	`LRUPR_ASSERT_NEXT(a_final_clears_run, upd_fire && last_s1, (valid_q == '0) && (fault_q == '0) && (hit_q == '0), "run state not cleared after final reference")
	`LRUPR_ASSERT_NOW(a_hit_never_evicts, out_valid_q, !(out_q.hit && out_q.evicted_valid), "hit reported with eviction")

endmodule

`default_nettype wire

/* sim/testbench.sv */
// Self-checking testbench for the LRU page replacement block (lru_page_replacement).
// Predicts every lookup result with its own model of the frame table and compares it per field.
// Depends on lrupr_pkg and the lru_page_replacement RTL.
module testbench;
	import lrupr_pkg::*;

	// Cycles without any transfer on either channel before the run is declared hung.
	localparam int WATCHDOG_LIMIT = 4000;
	// Length of the long output hold-off that fills the input queue.
	localparam int HOLD_CYCLES    = 80;
	localparam int POOL_DEPTH     = 32;

	// Model of the frame table. Every accepted reference is run through it at once,
	// and the lookup result it produces waits in a queue until the block delivers its own.
	class page_frame_predictor;
		logic [PAGE_FIELD_W-1:0] frame_page[FRAMES];
		bit                      frame_used[FRAMES];
		logic [RANK_W-1:0]       frame_age[FRAMES];
		logic [CNT_W-1:0]        fault_count;
		logic [CNT_W-1:0]        hit_count;
		logic [CFG_W-1:0]        frame_count;
		out_item_t               predicted_lookups[$];
		int                      mismatch_count;

		function new();
			foreach (frame_page[i])
				frame_page[i] = '0;
			frame_count    = CFG_RESET;
			mismatch_count = 0;
			clear_run();
		endfunction

		// Valid bits, ages and totals go back to zero; pages and the frame count stay.
		function void clear_run();
			foreach (frame_used[i]) begin
				frame_used[i] = 1'b0;
				frame_age[i]  = '0;
			end
			fault_count = '0;
			hit_count   = '0;
		endfunction

		// A frame count of zero still manages one frame, and counts above the
		// table size are clipped to it.
		function int active_count();
			if (frame_count == 0)
				return 1;
			if (frame_count > FRAMES)
				return FRAMES;
			return frame_count;
		endfunction

		// The slot becomes the youngest; used frames younger than it age by one.
		function void promote(int s);
			logic [RANK_W-1:0] r;
			r = frame_age[s];
			for (int j = 0; j < FRAMES; j++) begin
				if (j != s && frame_used[j] && frame_age[j] < r)
					frame_age[j]++;
			end
			frame_age[s] = '0;
		endfunction

		function void note_reference(in_item_t ref_in);
			out_item_t want;
			int        n;
			int        s;
			bit        found;
			bit        empty;
			n     = active_count();
			s     = 0;
			found = 1'b0;
			empty = 1'b0;
			want  = '0;
			// Only the active frames are searched, lowest slot first.
			for (int i = 0; i < n; i++) begin
				if (!found && frame_used[i] && frame_page[i] == ref_in.page_number) begin
					found = 1'b1;
					s     = i;
				end
			end
			if (found) begin
				promote(s);
				if (hit_count != CNT_MAX)
					hit_count++;
			end else begin
				for (int i = 0; i < n; i++) begin
					if (!empty && !frame_used[i]) begin
						empty = 1'b1;
						s     = i;
					end
				end
				if (empty) begin
					// Filling an empty frame ages every used frame, up to the oldest rank.
					for (int i = 0; i < FRAMES; i++) begin
						if (frame_used[i] && frame_age[i] < FRAMES - 1)
							frame_age[i]++;
					end
					frame_used[s] = 1'b1;
					frame_age[s]  = '0;
				end else begin
					// Oldest active frame goes; on equal ages the lowest slot wins.
					s = 0;
					for (int i = 1; i < n; i++) begin
						if (frame_age[i] > frame_age[s])
							s = i;
					end
					want.evicted_valid = 1'b1;
					want.evicted_page  = frame_page[s];
					promote(s);
				end
				frame_page[s] = ref_in.page_number;
				if (fault_count != CNT_MAX)
					fault_count++;
			end
			want.hit         = found;
			want.frame_slot  = s[SLOT_FIELD_W-1:0];
			want.fault_total = fault_count;
			want.hit_total   = hit_count;
			predicted_lookups.push_back(want);
			// The result still reports the closing reference; the run clears after it.
			if (ref_in.final_reference)
				clear_run();
		endfunction

		function void check_lookup(out_item_t got);
			out_item_t want;
			if (predicted_lookups.size() == 0) begin
				mismatch_count++;
				$display("%0t: lookup result with none outstanding: expected none, actual %h",
					$time, got);
				return;
			end
			want = predicted_lookups.pop_front();
			if (got.hit !== want.hit || got.frame_slot !== want.frame_slot ||
					got.evicted_valid !== want.evicted_valid ||
					got.evicted_page !== want.evicted_page ||
					got.fault_total !== want.fault_total ||
					got.hit_total !== want.hit_total) begin
				mismatch_count++;
				$display("%0t: lookup mismatch: expected hit=%0d slot=%0d evict=%0d/%h faults=%0d hits=%0d",
					$time, want.hit, want.frame_slot, want.evicted_valid, want.evicted_page,
					want.fault_total, want.hit_total);
				$display("%0t:                    actual hit=%0d slot=%0d evict=%0d/%h faults=%0d hits=%0d",
					$time, got.hit, got.frame_slot, got.evicted_valid, got.evicted_page,
					got.fault_total, got.hit_total);
			end
		endfunction

		function int pending();
			return predicted_lookups.size();
		endfunction
	endclass

	// Every input of the block starts at a known value.
	logic             clk       = 1'b0;
	logic             arst_n    = 1'b0;
	logic             cfg_we    = 1'b0;
	logic [CFG_W-1:0] cfg_wdata = '0;
	logic             in_valid  = 1'b0;
	in_item_t         in_data   = '0;
	logic             out_stall = 1'b0;
	logic             in_stall;
	logic             out_valid;
	out_item_t        out_data;

	page_frame_predictor   frame_model;
	int                    tx_idle_pct = 0;
	int                    rx_idle_pct = 0;
	bit                    hold_request = 1'b0;
	int                    quiet_cycles = 0;
	logic [PAGE_FIELD_W-1:0] page_pool[POOL_DEPTH];

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	lru_page_replacement dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data (out_data)
	);

	// All sampling happens at the rising edge, where the block's outputs still hold
	// their values from before the edge. Every transfer on the input side feeds the
	// predictor and every transfer on the output side is checked. The same block
	// keeps the watchdog: a long run of cycles with no transfer at all means the
	// block has hung.
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall)
				frame_model.note_reference(in_data);
			if (out_valid && !out_stall)
				frame_model.check_lookup(out_data);
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("%0t: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
				$display("== FAIL ==");
				$finish;
			end
		end
	end

	// Result side. It stalls at random at the current rate, and when asked it holds
	// the output off for a long stretch, counting the cycles itself, so that the
	// input queue fills up while the sender keeps offering references.
	initial begin
		int hold_left;
		hold_left = 0;
		forever begin
			@(negedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				hold_left    = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				out_stall <= 1'b1;
				hold_left--;
			end else begin
				out_stall <= ($urandom_range(99) < rx_idle_pct);
			end
		end
	end

	// Offers one reference. Gaps are inserted at random before it; once valid is up
	// the payload holds until the transfer, which is seen at a rising edge with
	// in_stall low. Valid stays high on return so that back-to-back references keep
	// it high without a drop.
	task automatic send_ref(input logic [PAGE_FIELD_W-1:0] page, input bit last);
		bit offered;
		offered = 1'b0;
		while (!offered) begin
			@(negedge clk);
			if ($urandom_range(99) < tx_idle_pct) begin
				in_valid <= 1'b0;
			end else begin
				in_valid                <= 1'b1;
				in_data.page_number     <= page;
				in_data.final_reference <= last;
				offered = 1'b1;
			end
		end
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
	endtask

	// The frame count is only written with nothing in flight: valid drops, then every
	// outstanding lookup must have come back. Each reference yields exactly one
	// result, so an empty queue means the block is idle.
	task automatic write_frames(input logic [CFG_W-1:0] value);
		@(negedge clk);
		in_valid <= 1'b0;
		while (frame_model.pending() != 0)
			@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		frame_model.frame_count = value;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic void refill_pool();
		foreach (page_pool[i])
			page_pool[i] = $urandom_range(16'hFFFF);
	endfunction

	// Reference streams with locality: pages mostly come from a small pool a little
	// larger than the active frame count, so hits, fills and evictions all occur.
	// A few pages are drawn from the whole range. Runs end at random with a final
	// reference, and the frame count moves every so often, frequently in mid-run,
	// so frames beyond the active count keep stale contents and later return.
	task automatic run_random(input int count);
		int                      n;
		int                      pick;
		logic [PAGE_FIELD_W-1:0] page;
		bit                      last;
		refill_pool();
		for (int k = 0; k < count; k++) begin
			if (k % 60 == 59) begin
				pick = $urandom_range(9);
				case (pick)
					0: write_frames('0);
					1: write_frames(CFG_W'($urandom_range(31, FRAMES + 1)));
					2: write_frames(CFG_W'(FRAMES));
					3: write_frames(CFG_W'(1));
					default: write_frames(CFG_W'($urandom_range(FRAMES, 1)));
				endcase
			end
			n = frame_model.active_count();
			if ($urandom_range(19) == 0)
				page = $urandom_range(16'hFFFF);
			else
				page = page_pool[$urandom_range((n + 3 > POOL_DEPTH - 1) ? POOL_DEPTH - 1 : n + 3)];
			last = ($urandom_range(39) == 0);
			send_ref(page, last);
			if (last)
				refill_pool();
		end
	endtask

	initial begin
		frame_model = new();
		tx_idle_pct = 11;
		rx_idle_pct = 64;

		// Reset is held at the start and released once, away from the rising edge.
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;

		// Directed part, starting at the reset frame count of 16. Page numbers cover
		// both extremes; the first references fill empty frames in slot order,
		// then hits on resident pages reorder the ages.
		send_ref(16'h0000, 1'b0);
		send_ref(16'hFFFF, 1'b0);
		send_ref(16'h0000, 1'b0);
		send_ref(16'hA5A5, 1'b0);
		send_ref(16'h5A5A, 1'b0);
		send_ref(16'h0001, 1'b0);
		send_ref(16'h0002, 1'b0);
		send_ref(16'h0003, 1'b0);
		send_ref(16'hFFFF, 1'b0);
		// Shrink mid-run: page 3 sits in an inactive frame, so it faults and evicts.
		write_frames(CFG_W'(3));
		send_ref(16'h0003, 1'b0);
		send_ref(16'h8000, 1'b0);
		send_ref(16'h0001, 1'b0);
		// Grow again: the frames that were parked become visible with their old pages.
		write_frames(CFG_W'(FRAMES));
		send_ref(16'h0002, 1'b0);
		send_ref(16'h7FFF, 1'b1);
		// A frame count of zero behaves as a single frame.
		write_frames('0);
		send_ref(16'h0007, 1'b0);
		send_ref(16'h0007, 1'b0);
		send_ref(16'h0008, 1'b0);
		send_ref(16'h0008, 1'b1);
		// All ones is beyond the table and is clipped to sixteen frames.
		write_frames('1);
		send_ref(16'h0009, 1'b0);
		send_ref(16'h0009, 1'b1);

		// Random part, first with a slow receiver, then with a slow sender.
		run_random(250);
		tx_idle_pct = 64;
		rx_idle_pct = 11;
		run_random(250);

		// No idling at all; halfway through, the receiver holds off for a long stretch
		// so the queue fills and in_stall has to rise.
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		run_random(125);
		hold_request = 1'b1;
		run_random(125);

		// Drain: wait for every outstanding lookup, then keep running so that
		// any stray result would still be caught.
		@(negedge clk);
		in_valid <= 1'b0;
		while (frame_model.pending() != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);
		if (frame_model.mismatch_count == 0 && frame_model.pending() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
